// ===== design/mmtb_pkg.sv =====
// Package for matrix_multiply_transposed_b: item field widths, op codes,
// sequencer state type and output saturation limits. No dependencies.
package mmtb_pkg;

   localparam int OP_W    = 2;
   localparam int ROW_W   = 4;
   localparam int COL_W   = 6;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int OUT_W   = 38;
   localparam int REQ_DW  = 32;
   localparam int RSP_DW  = 40;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;
   localparam int ROWS_REG_W = 5;
   localparam int COLS_REG_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_QUERY   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   localparam logic signed [OUT_W-1:0] SUM_HIGH = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] SUM_LOW  = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== design/matrix_multiply_transposed_b.sv =====
// Matrix product with transposed B, one entry per query item.
// Uses mmtb_pkg for field widths, op codes and the sequencer state type.
//
// Load items (op 0/1) write one Q8.8 element of A or B.
// A query item (op 2) names row i of A (row_index) and row j of B (col_index,
// modulo ROWS_MAX) and returns sum over k < cols_in_use of A[i][k]*B[j][k] as
// a saturated signed Q22.16 value. One shared 16x16 multiplier and one
// accumulator walk the column pairs, one pair per cycle from the two element
// memories; the input is not ready during that walk. A result waiting on
// rsp does not stop loads. Element memories are not cleared: read only
// written elements.
module matrix_multiply_transposed_b #(
   parameter int ROWS_MAX = 16,
   parameter int COLS_MAX = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [3:0] row_index, [9:4] col_index, [25:10] element_value, [31:26] zero
   input  logic [mmtb_pkg::REQ_DW-1:0] req_tdata,
   // [1:0] op
   input  logic [mmtb_pkg::OP_W-1:0]   req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [37:0] product_entry, [39:38] zero
   output logic [mmtb_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mmtb_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [mmtb_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [mmtb_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam int DEPTH = ROWS_MAX * COLS_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RIW   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
   localparam int KAW   = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
   localparam int RW    = ($clog2(ROWS_MAX + 1) > mmtb_pkg::ROWS_REG_W) ?
                          $clog2(ROWS_MAX + 1) : mmtb_pkg::ROWS_REG_W;
   localparam int CW    = ($clog2(COLS_MAX + 1) > mmtb_pkg::COLS_REG_W) ?
                          $clog2(COLS_MAX + 1) : mmtb_pkg::COLS_REG_W;
   localparam int ACC_W = 33 + $clog2(COLS_MAX);
   localparam int SW    = (ACC_W > mmtb_pkg::OUT_W) ? ACC_W : mmtb_pkg::OUT_W;
   localparam int LUT_N = 1 << mmtb_pkg::COL_W;

   // field unpack
   mmtb_pkg::op_type                  op;
   logic [mmtb_pkg::ROW_W-1:0]        row_index;
   logic [mmtb_pkg::COL_W-1:0]        col_index;
   logic signed [mmtb_pkg::ELEM_W-1:0] element_value;

   assign op            = mmtb_pkg::op_type'(req_tuser);
   assign row_index     = req_tdata[3:0];
   assign col_index     = req_tdata[9:4];
   assign element_value = req_tdata[25:10];

   // row modulo ROWS_MAX, constant table
   logic [RIW-1:0] mod_lut [LUT_N];
   for (genvar g = 0; g < LUT_N; g++) begin : g_mod
      assign mod_lut[g] = RIW'(g % ROWS_MAX);
   end

   // registers
   mmtb_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [AW-1:0]       a_base_ff, a_base_in;
   logic [AW-1:0]       b_base_ff, b_base_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                mul_vld_ff, mul_vld_in;
   logic signed [mmtb_pkg::ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic signed [mmtb_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]            acc_ff, acc_in;
   logic                               rsp_vld_ff, rsp_vld_in;
   logic [mmtb_pkg::OUT_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [RW-1:0]                      rows_ff, rows_in;
   logic [CW-1:0]                      cols_ff, cols_in;

   logic [mmtb_pkg::ELEM_W-1:0] a_mem [DEPTH];
   logic [mmtb_pkg::ELEM_W-1:0] b_mem [DEPTH];

   logic                   req_acc;
   logic                   wr_ok;
   logic [31:0]            wr_addr_wide;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          a_addr, b_addr;
   logic                   issue;
   logic signed [SW-1:0]   acc_ext;
   logic                   csr_wr;
   logic [RW-1:0]          rows_wv;
   logic [CW-1:0]          cols_wv;

   assign req_tready = (state_ff == mmtb_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign wr_addr_wide = 32'(row_index) * 32'(COLS_MAX) + 32'(col_index);
   assign wr_addr      = wr_addr_wide[AW-1:0];
   assign wr_ok        = (32'(row_index) < 32'(ROWS_MAX)) &&
                         (32'(col_index) < 32'(COLS_MAX));

   assign issue  = (state_ff == mmtb_pkg::ST_RUN) && (k_ff < cols_ff);
   assign a_addr = a_base_ff + AW'(k_ff[KAW-1:0]);
   assign b_addr = b_base_ff + AW'(k_ff[KAW-1:0]);
   assign acc_ext = SW'(acc_ff);

   // element memories
   always_ff @(posedge clock) begin
      if (req_acc && wr_ok && op == mmtb_pkg::OP_WRITE_A) begin
         a_mem[wr_addr] <= element_value;
      end
      if (req_acc && wr_ok && op == mmtb_pkg::OP_WRITE_B) begin
         b_mem[wr_addr] <= element_value;
      end
      a_rd_ff <= a_mem[a_addr];
      b_rd_ff <= b_mem[b_addr];
   end

   // config
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? mmtb_pkg::CSR_DW'(cols_ff) :
                                      mmtb_pkg::CSR_DW'(rows_ff);

   always_comb begin
      rows_wv = RW'(csr_pwdata[4:0]);
      cols_wv = CW'(csr_pwdata[6:0]);
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr && !csr_paddr[2]) begin
         if (rows_wv == '0) begin
            rows_in = RW'(1);
         end else if (rows_wv > RW'(ROWS_MAX)) begin
            rows_in = RW'(ROWS_MAX);
         end else begin
            rows_in = rows_wv;
         end
      end
      if (csr_wr && csr_paddr[2]) begin
         if (cols_wv == '0) begin
            cols_in = CW'(1);
         end else if (cols_wv > CW'(COLS_MAX)) begin
            cols_in = CW'(COLS_MAX);
         end else begin
            cols_in = cols_wv;
         end
      end
   end

   function automatic logic signed [mmtb_pkg::PROD_W-1:0] PROD_W_MUL(
      input logic signed [mmtb_pkg::ELEM_W-1:0] x,
      input logic signed [mmtb_pkg::ELEM_W-1:0] y
   );
      return x * y;
   endfunction

   // sequencer and MAC
   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      a_base_in   = a_base_ff;
      b_base_in   = b_base_ff;
      rd_vld_in   = issue;
      mul_vld_in  = rd_vld_ff;
      prod_in     = PROD_W_MUL(a_rd_ff, b_rd_ff);
      acc_in      = acc_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (mul_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      if (issue) begin
         k_in = k_ff + CW'(1);
      end
      unique case (state_ff)
         mmtb_pkg::ST_IDLE: begin
            if (req_acc && op == mmtb_pkg::OP_QUERY) begin
               a_base_in = AW'(mod_lut[mmtb_pkg::COL_W'(row_index)]) * AW'(COLS_MAX);
               b_base_in = AW'(mod_lut[col_index]) * AW'(COLS_MAX);
               k_in      = '0;
               acc_in    = '0;
               state_in  = mmtb_pkg::ST_RUN;
            end
         end
         mmtb_pkg::ST_RUN: begin
            if (!issue && !rd_vld_ff && !mul_vld_ff) begin
               state_in = mmtb_pkg::ST_FIN;
            end
         end
         mmtb_pkg::ST_FIN: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               if (acc_ext > SW'(mmtb_pkg::SUM_HIGH)) begin
                  rsp_data_in = mmtb_pkg::SUM_HIGH;
               end else if (acc_ext < SW'(mmtb_pkg::SUM_LOW)) begin
                  rsp_data_in = mmtb_pkg::SUM_LOW;
               end else begin
                  rsp_data_in = acc_ext[mmtb_pkg::OUT_W-1:0];
               end
               state_in = mmtb_pkg::ST_IDLE;
            end
         end
         default: state_in = mmtb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mmtb_pkg::ST_IDLE;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         rows_ff    <= RW'(ROWS_MAX);
         cols_ff    <= CW'(COLS_MAX);
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= mul_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         rows_ff    <= rows_in;
         cols_ff    <= cols_in;
         k_ff       <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      a_base_ff   <= a_base_in;
      b_base_ff   <= b_base_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = mmtb_pkg::RSP_DW'(rsp_data_ff);

`ifndef ASSERT_OFF
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && op == mmtb_pkg::OP_QUERY) |=> (state_ff == mmtb_pkg::ST_RUN))
      else $error("query accepted without starting the column walk");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmtb_pkg::ST_RUN) |-> (k_ff <= cols_ff))
      else $error("column counter past cols_in_use");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == mmtb_pkg::ST_FIN))
      else $error("result item raised outside the finish state");

   a_pipe_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmtb_pkg::ST_IDLE) |-> (!rd_vld_ff && !mul_vld_ff))
      else $error("MAC pipeline busy while idle");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for matrix_multiply_transposed_b: loads A/B elements,
// issues dot-product queries and compares each product item to its own prediction.
// Depends on mmtb_pkg and the matrix_multiply_transposed_b RTL only.
module testbench;

   localparam int ROWS = 16;
   localparam int COLS = 64;
   localparam logic [mmtb_pkg::CSR_AW-1:0] ADDR_ROWS = 3'd0;
   localparam logic [mmtb_pkg::CSR_AW-1:0] ADDR_COLS = 3'd4;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 200;

   typedef struct {
      mmtb_pkg::op_type                op;
      logic [mmtb_pkg::ROW_W-1:0]  row;
      logic [mmtb_pkg::COL_W-1:0]  col;
      logic [mmtb_pkg::ELEM_W-1:0] value;
   } req_item_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [mmtb_pkg::REQ_DW-1:0]   req_tdata = '0;
   logic [mmtb_pkg::OP_W-1:0]     req_tuser = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [mmtb_pkg::RSP_DW-1:0]   rsp_tdata;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [mmtb_pkg::CSR_AW-1:0]   csr_paddr = '0;
   logic [mmtb_pkg::CSR_DW-1:0]   csr_pwdata = '0;
   logic [mmtb_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   matrix_multiply_transposed_b u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // stimulus side
   req_item_type pending_items[$];
   bit      a_filled[ROWS][COLS];
   bit      b_filled[ROWS][COLS];
   int      items_sent = 0;
   bit      idle_on = 1'b1;
   int      gap_left = 0;
   int      stall_left = 0;

   // prediction side
   logic signed [mmtb_pkg::ELEM_W-1:0] a_mem[ROWS][COLS];
   logic signed [mmtb_pkg::ELEM_W-1:0] b_mem[ROWS][COLS];
   logic signed [mmtb_pkg::OUT_W-1:0]  product_expect[$];
   int rows_setting = ROWS;
   int cols_setting = COLS;
   int mismatches = 0;

   logic [mmtb_pkg::ROW_W-1:0]        seen_row;
   logic [mmtb_pkg::COL_W-1:0]        seen_col;
   logic [mmtb_pkg::ELEM_W-1:0]       seen_val;
   logic signed [mmtb_pkg::OUT_W-1:0] want_product;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("matrix_multiply_transposed_b test failed");
      $finish;
   end

   function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      if (mismatches < 10)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
   endfunction

   function automatic int clamp_reg(int v, int maxv);
      if (v == 0)
         return 1;
      if (v > maxv)
         return maxv;
      return v;
   endfunction

   function automatic logic signed [mmtb_pkg::OUT_W-1:0] dot_product(int i, int j);
      longint acc;
      acc = 0;
      for (int k = 0; k < cols_setting; k++)
         acc += longint'(a_mem[i][k]) * longint'(b_mem[j][k]);
      if (acc > longint'(mmtb_pkg::SUM_HIGH))
         acc = longint'(mmtb_pkg::SUM_HIGH);
      if (acc < longint'(mmtb_pkg::SUM_LOW))
         acc = longint'(mmtb_pkg::SUM_LOW);
      return acc[mmtb_pkg::OUT_W-1:0];
   endfunction

   function automatic logic [mmtb_pkg::ELEM_W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
               gap_left <= $urandom_range(0, 2);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= {6'b0, pending_items[0].value, pending_items[0].col,
                             pending_items[0].row};
               req_tuser <= pending_items[0].op;
               void'(pending_items.pop_front());
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: track stores on accepted items, check product items
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen_row = req_tdata[mmtb_pkg::ROW_W-1:0];
            seen_col = req_tdata[mmtb_pkg::ROW_W+mmtb_pkg::COL_W-1:mmtb_pkg::ROW_W];
            seen_val = req_tdata[mmtb_pkg::ROW_W+mmtb_pkg::COL_W+mmtb_pkg::ELEM_W-1:
                                 mmtb_pkg::ROW_W+mmtb_pkg::COL_W];
            case (mmtb_pkg::op_type'(req_tuser))
               mmtb_pkg::OP_WRITE_A: a_mem[seen_row][seen_col] = seen_val;
               mmtb_pkg::OP_WRITE_B: b_mem[seen_row][seen_col] = seen_val;
               mmtb_pkg::OP_QUERY:
                  product_expect.push_back(dot_product(int'(seen_row),
                                                       int'(seen_col) % ROWS));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (product_expect.size() == 0) begin
               note_mismatch("unexpected product", '0,
                             64'(rsp_tdata[mmtb_pkg::OUT_W-1:0]));
            end else begin
               want_product = product_expect.pop_front();
               if (rsp_tdata[mmtb_pkg::OUT_W-1:0] !== want_product)
                  note_mismatch("product_entry",
                                64'(want_product[mmtb_pkg::OUT_W-1:0]),
                                64'(rsp_tdata[mmtb_pkg::OUT_W-1:0]));
            end
         end
      end
   end

   task automatic csr_write(logic [mmtb_pkg::CSR_AW-1:0] addr,
                            logic [mmtb_pkg::CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check(logic [mmtb_pkg::CSR_AW-1:0] addr, int want);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== mmtb_pkg::CSR_DW'(want))
         note_mismatch("register readback", 64'(want), 64'(csr_prdata));
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(int rows_val, int cols_val);
      logic [mmtb_pkg::CSR_DW-1:0] noise;
      noise = $urandom;
      csr_write(ADDR_ROWS, (noise & ~32'h1f) | mmtb_pkg::CSR_DW'(rows_val));
      rows_setting = clamp_reg(rows_val, ROWS);
      csr_check(ADDR_ROWS, rows_setting);
      noise = $urandom;
      csr_write(ADDR_COLS, (noise & ~32'h7f) | mmtb_pkg::CSR_DW'(cols_val));
      cols_setting = clamp_reg(cols_val, COLS);
      csr_check(ADDR_COLS, cols_setting);
   endtask

   task automatic add_load(mmtb_pkg::op_type op, int row, int col,
                           logic [mmtb_pkg::ELEM_W-1:0] val);
      req_item_type it;
      it.op = op;
      it.row = mmtb_pkg::ROW_W'(row);
      it.col = mmtb_pkg::COL_W'(col);
      it.value = val;
      pending_items.push_back(it);
      if (op == mmtb_pkg::OP_WRITE_A)
         a_filled[row][col] = 1'b1;
      else
         b_filled[row][col] = 1'b1;
      items_sent++;
   endtask

   task automatic add_noise();
      req_item_type it;
      it.op = mmtb_pkg::OP_NONE;
      it.row = mmtb_pkg::ROW_W'($urandom);
      it.col = mmtb_pkg::COL_W'($urandom);
      it.value = mmtb_pkg::ELEM_W'($urandom);
      pending_items.push_back(it);
   endtask

   // a query only reads elements already written: fill the gaps first
   task automatic add_query(int row, int colidx);
      req_item_type it;
      int j;
      j = colidx % ROWS;
      for (int k = 0; k < cols_setting; k++) begin
         if (!a_filled[row][k])
            add_load(mmtb_pkg::OP_WRITE_A, row, k, rand_value());
         if (!b_filled[j][k])
            add_load(mmtb_pkg::OP_WRITE_B, j, k, rand_value());
      end
      it.op = mmtb_pkg::OP_QUERY;
      it.row = mmtb_pkg::ROW_W'(row);
      it.col = mmtb_pkg::COL_W'(colidx);
      it.value = mmtb_pkg::ELEM_W'($urandom);
      pending_items.push_back(it);
      items_sent++;
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || product_expect.size() != 0);
      repeat (cols_setting + 8) @(negedge clock);
   endtask

   task automatic random_items(int budget);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < budget) begin
         pick = $urandom_range(0, 19);
         if (pick < 10)
            add_query($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
         else if (pick < 18)
            add_load($urandom_range(0, 1) ? mmtb_pkg::OP_WRITE_B : mmtb_pkg::OP_WRITE_A,
                     $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1), rand_value());
         else
            add_noise();
      end
   endtask

   initial begin
      int rows_plan[PHASES];
      int cols_plan[PHASES];
      rows_plan = '{0, 16, 31, 5, 1, 20, 9, 16};
      cols_plan = '{1, 0, 2, 8, 3, 127, 24, 6};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      csr_check(ADDR_ROWS, ROWS);
      csr_check(ADDR_COLS, COLS);

      // directed: field extremes, row j from the low col bits, ignored op
      set_config(16, 4);
      @(negedge clock);
      add_load(mmtb_pkg::OP_WRITE_A, 0, 0, 16'h7fff);
      add_load(mmtb_pkg::OP_WRITE_A, 0, 1, 16'h8000);
      add_load(mmtb_pkg::OP_WRITE_A, 0, 2, 16'hffff);
      add_load(mmtb_pkg::OP_WRITE_A, 0, 3, 16'h0001);
      add_load(mmtb_pkg::OP_WRITE_B, 15, 0, 16'h7fff);
      add_load(mmtb_pkg::OP_WRITE_B, 15, 1, 16'h8000);
      add_load(mmtb_pkg::OP_WRITE_B, 15, 2, 16'h8000);
      add_load(mmtb_pkg::OP_WRITE_B, 15, 3, 16'h0000);
      add_load(mmtb_pkg::OP_WRITE_A, 15, 63, 16'h8000);
      add_load(mmtb_pkg::OP_WRITE_B, 0, 63, 16'h7fff);
      add_query(0, 15);
      add_query(0, 63);
      add_noise();
      add_query(15, 0);
      add_query(15, 48);
      wait_idle();

      // full-width sums at the largest magnitudes
      set_config(31, 64);
      @(negedge clock);
      for (int k = 0; k < COLS; k++) begin
         add_load(mmtb_pkg::OP_WRITE_A, 14, k, 16'h8000);
         add_load(mmtb_pkg::OP_WRITE_B, 14, k, 16'h8000);
         add_load(mmtb_pkg::OP_WRITE_A, 13, k, 16'h7fff);
         add_load(mmtb_pkg::OP_WRITE_B, 13, k, 16'h7fff);
      end
      add_query(14, 14);
      add_query(14, 29);
      add_query(13, 61);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         idle_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         set_config(rows_plan[p], cols_plan[p]);
         @(negedge clock);
         random_items(PHASE_ITEMS);
         wait_idle();
      end

      if (mismatches == 0 && product_expect.size() == 0)
         $display("matrix_multiply_transposed_b test passed");
      else
         $display("matrix_multiply_transposed_b test failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/mmtb_pkg.sv
design/matrix_multiply_transposed_b.sv
tb/testbench.sv
